/* src/pvc_pkg.sv */
// Package for the PID velocity controller: shared widths, register indexes,
// the sequencer state type and the status word of the serial units.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pvc_pkg;

    // The error accumulator is a plain 64-bit signed word at every data width.
    localparam int SUM_W = 64;

    // Configuration registers, in address order.
    localparam int NUM_REGS = 3;
    localparam int REG_KP = 0;
    localparam int REG_KI = 1;
    localparam int REG_KD = 2;

    // Top-level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MAC,
        ST_OUT
    } pvc_state_t;

    // Status of a serial unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

/* src/pvc_div.sv */
// Bit-serial restoring divider for the mean error: 64-bit signed dividend
// over an unsigned divisor, one quotient bit per cycle, clamped result.
// Depends on pvc_pkg.
`default_nettype none

module pvc_div #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pvc_pkg::SUM_W-1:0]    dividend,
    input  logic        [COUNT_WIDTH:0]         divisor,
    output logic signed [DATA_WIDTH-1:0]        quotient,
    output pvc_pkg::unit_stat_t                 stat
);
    import pvc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic [SUM_W-1:0]       num_reg, num_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH:0]   dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [SUM_W-1:0]       mag;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   trial_sub;
    logic                   fits;
    logic                   ovf_pos;
    logic                   ovf_neg;
    logic [DATA_WIDTH-1:0]  q_low;

    // Shift the dividend magnitude out at the top while quotient bits
    // enter at the bottom; after all steps num_reg holds |quotient|.
    always_comb
    begin
        mag       = dividend[SUM_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
        trial     = {rem_reg, num_reg[SUM_W-1]};
        trial_sub = trial - dvs_reg;
        fits      = (trial >= dvs_reg);

        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = mag;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_W-1];
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[SUM_W-2:0], fits};
            rem_next  = fits ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Clamp the signed quotient to the data range.
    always_comb
    begin
        q_low   = num_reg[DATA_WIDTH-1:0];
        ovf_pos = |num_reg[SUM_W-1:DATA_WIDTH-1];
        ovf_neg = (|num_reg[SUM_W-1:DATA_WIDTH])
                | (num_reg[DATA_WIDTH-1] & (|num_reg[DATA_WIDTH-2:0]));
        if (neg_reg)
        begin
            quotient = ovf_neg ? $signed(DMIN) : $signed(-q_low);
        end
        else
        begin
            quotient = ovf_pos ? $signed(DMAX) : $signed(q_low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* src/pvc_mac.sv */
// Bit-serial multiply-accumulate for the three PID terms: one multiplier bit
// of each term per cycle, then shift, round down and saturate.
// Depends on pvc_pkg.
`default_nettype none

module pvc_mac #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] kp,
    input  logic signed [DATA_WIDTH-1:0] ki,
    input  logic signed [DATA_WIDTH-1:0] kd,
    input  logic signed [DATA_WIDTH:0]   mul_p,
    input  logic signed [DATA_WIDTH:0]   mul_i,
    input  logic signed [DATA_WIDTH:0]   mul_d,
    output logic        [DATA_WIDTH-1:0] correction,
    output logic                         sat,
    output pvc_pkg::unit_stat_t          stat
);
    import pvc_pkg::*;

    // Multipliers are DATA_WIDTH+1 bits; the running high word needs two
    // guard bits over a single product for the sum of three.
    localparam int L_W    = DATA_WIDTH + 1;
    localparam int H_W    = DATA_WIDTH + 3;
    localparam int F_W    = H_W + L_W;
    localparam int TOP_LO = FRAC_BITS + DATA_WIDTH - 1;
    localparam int STEP_W = $clog2(L_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_WIDTH);
    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic signed [H_W-1:0] hi_reg, hi_next;
    logic [L_W-1:0]        lo_reg, lo_next;
    logic [L_W-1:0]        xp_reg, xp_next;
    logic [L_W-1:0]        xi_reg, xi_next;
    logic [L_W-1:0]        xd_reg, xd_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic                  last;
    logic signed [H_W-1:0] tp;
    logic signed [H_W-1:0] ti;
    logic signed [H_W-1:0] td;
    logic signed [H_W-1:0] sum;
    logic [F_W-1:0]        full;
    logic [F_W-TOP_LO-1:0] top_bits;
    logic                  in_range;

    always_comb
    begin
        last = (step_reg == LAST_STEP);
        tp   = xp_reg[0] ? H_W'(kp) : '0;
        ti   = xi_reg[0] ? H_W'(ki) : '0;
        td   = xd_reg[0] ? H_W'(kd) : '0;
        // The top multiplier bit carries negative weight.
        if (last)
        begin
            tp = -tp;
            ti = -ti;
            td = -td;
        end
        sum = hi_reg + tp + ti + td;

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        xp_next   = xp_reg;
        xi_next   = xi_reg;
        xd_next   = xd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            hi_next   = '0;
            lo_next   = '0;
            xp_next   = mul_p;
            xi_next   = mul_i;
            xd_next   = mul_d;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next   = sum >>> 1;
            lo_next   = {sum[0], lo_reg[L_W-1:1]};
            xp_next   = {1'b0, xp_reg[L_W-1:1]};
            xi_next   = {1'b0, xi_reg[L_W-1:1]};
            xd_next   = {1'b0, xd_reg[L_W-1:1]};
            step_next = step_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Dropping the fraction bits of a two's complement word rounds toward
    // minus infinity; the result fits when all bits above it match its sign.
    always_comb
    begin
        full     = {hi_reg, lo_reg};
        top_bits = full[F_W-1:TOP_LO];
        in_range = (&top_bits) | (~|top_bits);
        sat      = ~in_range;
        if (in_range)
        begin
            correction = full[TOP_LO:FRAC_BITS];
        end
        else
        begin
            correction = full[F_W-1] ? DMIN : DMAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        xp_reg <= xp_next;
        xi_reg <= xi_next;
        xd_reg <= xd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* src/pid_velocity_controller_core.sv */
// PID velocity controller: top level with the sequencer, the controller
// state, the APB register file and the stream ports.
// Depends on pvc_pkg, pvc_div and pvc_mac.
//
// Usage. Each input word on the s_axis channel carries a target and a measured
// velocity (signed, FRAC_BITS fraction bits). For each word the block returns
// one output word on m_axis: the saturated PID correction in tdata and a
// clipped flag in tuser, set when the error or the correction saturated.
// The integral term uses the mean of all errors seen so far, the derivative
// term the change since the last error (zero on the first word after reset).
//
// Sequence. One word is worked on at a time. The error is registered when the
// word is taken, then the controller state is updated, the mean is formed by a
// bit-serial divider (one quotient bit of the 64-bit error sum per cycle), and
// the three products are summed by a bit-serial multiply-accumulate. The next
// input word is taken only after the result has been loaded into the output
// register.
//
// Stalls. The result waits in an output register; if the receiver still holds
// off the previous word when a new result is ready, the block waits with
// s_axis_tready low. Reset clears the gains, the error sum, the sample count
// and the last error, and empties the output register. Gains are to be written
// through the APB port while the block is idle; the block does not enforce this.
`default_nettype none

module pid_velocity_controller_core #(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,

    // Input stream. tdata: target_speed, measured_speed.
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,

    // Output stream. tdata: correction. tuser: clipped.
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]  m_axis_tdata,
    output logic [0:0]                               m_axis_tuser,

    // Configuration port.
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [$clog2(((DATA_WIDTH > 32) ? 8 : 4) * pvc_pkg::NUM_REGS) - 1:0] paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32) - 1:0] pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32) - 1:0] prdata,
    output logic                                     pready
);
    import pvc_pkg::*;

    localparam int APB_DW  = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int ALIGN_W = (DATA_WIDTH > 32) ? 3 : 2;
    localparam int ADDR_W  = $clog2(((DATA_WIDTH > 32) ? 8 : 4) * NUM_REGS);
    localparam int IDX_W   = ADDR_W - ALIGN_W;
    localparam int OUT_W   = ((DATA_WIDTH + 7) / 8) * 8;

    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic [SUM_W-1:0]      SMAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic [SUM_W-1:0]      SMIN = {1'b1, {(SUM_W - 1){1'b0}}};

    // Gains.
    logic signed [DATA_WIDTH-1:0]  kp_reg, kp_next;
    logic signed [DATA_WIDTH-1:0]  ki_reg, ki_next;
    logic signed [DATA_WIDTH-1:0]  kd_reg, kd_next;

    // Controller history.
    logic signed [SUM_W-1:0]       error_sum_reg, error_sum_next;
    logic [COUNT_WIDTH-1:0]        sample_count_reg, sample_count_next;
    logic signed [DATA_WIDTH-1:0]  last_error_reg, last_error_next;

    // Per-word working registers.
    pvc_state_t                    state_reg, state_next;
    logic signed [DATA_WIDTH-1:0]  err_reg, err_next;
    logic                          clip_err_reg, clip_err_next;
    logic signed [DATA_WIDTH:0]    diff_reg, diff_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0]         out_corr_reg, out_corr_next;
    logic                          out_clip_reg, out_clip_next;

    // Sequencer outputs.
    logic                          accept;
    logic                          div_start;
    logic                          mac_start;
    logic                          out_load;

    // Datapath.
    logic signed [DATA_WIDTH-1:0]  t_in;
    logic signed [DATA_WIDTH-1:0]  m_in;
    logic signed [DATA_WIDTH:0]    err_wide;
    logic                          err_ovf;
    logic [DATA_WIDTH-1:0]         err_sat;
    logic signed [SUM_W-1:0]       err_ext;
    logic [SUM_W:0]                sum_wide;
    logic signed [SUM_W-1:0]       total;
    logic [COUNT_WIDTH:0]          divisor;
    logic signed [DATA_WIDTH-1:0]  mean;
    logic [DATA_WIDTH-1:0]         mac_corr;
    logic                          mac_sat;
    unit_stat_t                    div_stat;
    unit_stat_t                    mac_stat;

    // Register file.
    logic                          cfg_write;
    logic [IDX_W-1:0]              reg_idx;

    //------------------------------------------------------------------
    // Configuration port: zero wait states, register index from the
    // word-aligned address.
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:ALIGN_W];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        kp_next = kp_reg;
        ki_next = ki_reg;
        kd_next = kd_reg;
        if (cfg_write)
        begin
            if (reg_idx == IDX_W'(REG_KP))
            begin
                kp_next = pwdata[DATA_WIDTH-1:0];
            end
            if (reg_idx == IDX_W'(REG_KI))
            begin
                ki_next = pwdata[DATA_WIDTH-1:0];
            end
            if (reg_idx == IDX_W'(REG_KD))
            begin
                kd_next = pwdata[DATA_WIDTH-1:0];
            end
        end
    end

    // Reads return the gain sign-extended to the bus width.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == IDX_W'(REG_KP))
        begin
            prdata = APB_DW'(kp_reg);
        end
        else if (reg_idx == IDX_W'(REG_KI))
        begin
            prdata = APB_DW'(ki_reg);
        end
        else if (reg_idx == IDX_W'(REG_KD))
        begin
            prdata = APB_DW'(kd_reg);
        end
    end

    //------------------------------------------------------------------
    // Sequencer.
    //------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mac_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    mac_start  = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait until the previous word has left the output register.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Error: exact difference, saturated to the data range.
    //------------------------------------------------------------------
    always_comb
    begin
        t_in     = s_axis_tdata[DATA_WIDTH-1:0];
        m_in     = s_axis_tdata[2 * DATA_WIDTH - 1:DATA_WIDTH];
        err_wide = {t_in[DATA_WIDTH-1], t_in} - {m_in[DATA_WIDTH-1], m_in};
        err_ovf  = err_wide[DATA_WIDTH] ^ err_wide[DATA_WIDTH-1];
        if (err_ovf)
        begin
            err_sat = err_wide[DATA_WIDTH] ? DMIN : DMAX;
        end
        else
        begin
            err_sat = err_wide[DATA_WIDTH-1:0];
        end
        err_next      = accept ? $signed(err_sat) : err_reg;
        clip_err_next = accept ? err_ovf : clip_err_reg;
    end

    //------------------------------------------------------------------
    // History update in the cycle after the word is taken. The divider
    // picks up the new error sum and the old count plus one in that cycle.
    //------------------------------------------------------------------
    always_comb
    begin
        err_ext  = SUM_W'(err_reg);
        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg} + {err_ext[SUM_W-1], err_ext};
        if (sum_wide[SUM_W] ^ sum_wide[SUM_W-1])
        begin
            total = sum_wide[SUM_W] ? $signed(SMIN) : $signed(SMAX);
        end
        else
        begin
            total = sum_wide[SUM_W-1:0];
        end
        divisor = {1'b0, sample_count_reg} + 1'b1;

        error_sum_next    = error_sum_reg;
        sample_count_next = sample_count_reg;
        last_error_next   = last_error_reg;
        diff_next         = diff_reg;
        if (state_reg == ST_PREP)
        begin
            error_sum_next  = total;
            last_error_next = err_reg;
            if (~&sample_count_reg)
            begin
                sample_count_next = sample_count_reg + 1'b1;
            end
            // No derivative on the first sample after reset.
            if (sample_count_reg == '0)
            begin
                diff_next = '0;
            end
            else
            begin
                diff_next = {err_reg[DATA_WIDTH-1], err_reg}
                          - {last_error_reg[DATA_WIDTH-1], last_error_reg};
            end
        end
    end

    //------------------------------------------------------------------
    // Serial units.
    //------------------------------------------------------------------
    pvc_div #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total),
        .divisor  (divisor),
        .quotient (mean),
        .stat     (div_stat)
    );

    pvc_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mac_start),
        .kp         (kp_reg),
        .ki         (ki_reg),
        .kd         (kd_reg),
        .mul_p      ({err_reg[DATA_WIDTH-1], err_reg}),
        .mul_i      ({mean[DATA_WIDTH-1], mean}),
        .mul_d      (diff_reg),
        .correction (mac_corr),
        .sat        (mac_sat),
        .stat       (mac_stat)
    );

    //------------------------------------------------------------------
    // Output register.
    //------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_corr_next  = out_corr_reg;
        out_clip_next  = out_clip_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_corr_next  = mac_corr;
            out_clip_next  = clip_err_reg | mac_sat;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_W'(out_corr_reg);
    assign m_axis_tuser[0] = out_clip_reg;

    //------------------------------------------------------------------
    // Registers.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kp_reg           <= '0;
            ki_reg           <= '0;
            kd_reg           <= '0;
            error_sum_reg    <= '0;
            sample_count_reg <= '0;
            last_error_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kp_reg           <= kp_next;
            ki_reg           <= ki_next;
            kd_reg           <= kd_next;
            error_sum_reg    <= error_sum_next;
            sample_count_reg <= sample_count_next;
            last_error_reg   <= last_error_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        clip_err_reg <= clip_err_next;
        diff_reg     <= diff_next;
        out_corr_reg <= out_corr_next;
        out_clip_reg <= out_clip_next;
    end

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------
    // A new word is only taken when both serial units have finished.
    a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!div_stat.busy && !mac_stat.busy))
        else $error("input taken while a serial unit is busy");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    // The multiply-accumulate finishes only while the sequencer waits for it.
    a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.done |-> (state_reg == ST_MAC))
        else $error("multiply-accumulate finished outside its state");

    // The sample count never wraps back to zero.
    a_count_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_count_reg != '0) |=> (sample_count_reg != '0))
        else $error("sample count returned to zero");

endmodule

`default_nettype wire
